@@ rtl/fpw_pkg.sv @@
`default_nettype none

package fpw_pkg;

	localparam int unsigned VA_W    = 48;
	localparam int unsigned PA_W    = 52;
	localparam int unsigned FLAG_W  = 12;
	localparam int unsigned ENTRY_W = 64;
	localparam int unsigned IDX_W   = 9;
	localparam int unsigned PAGE_W  = 12;

	localparam int unsigned BIT_PRESENT  = 0;
	localparam int unsigned BIT_WRITABLE = 1;
	localparam int unsigned BIT_USER     = 2;
	localparam int unsigned BIT_HUGE     = 7;
	localparam int unsigned BIT_NX       = 63;

	typedef logic [2:0] status_t;

	localparam status_t ST_MAPPED  = 3'd0;
	localparam status_t ST_ALIGN   = 3'd1;
	localparam status_t ST_ALLOC   = 3'd2;
	localparam status_t ST_ALREADY = 3'd3;
	localparam status_t ST_XLATED  = 3'd4;
	localparam status_t ST_NOXLATE = 3'd5;

	localparam logic REQ_MAP       = 1'b0;
	localparam logic REQ_TRANSLATE = 1'b1;

	// Table index for each level: bits 47:39, 38:30, 29:21, 20:12.
	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ rtl/fpw_ram.sv @@
`default_nettype none

module fpw_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ rtl/four_level_page_table_walker.sv @@
// Channel | Direction | Signals                    | Contents
// request | in        | s_tvalid s_tready s_tdata  | tuser: req_type; tdata: see port
//         |           | s_tuser                    |
// result  | out       | m_tvalid m_tready m_tdata  | tuser: status; tdata: see port
//         |           | m_tuser                    |
// config  | in        | cfg_valid cfg_ready        | pool_base
//
// A request that walks all four levels goes through four read and check steps (S_RD, S_EV)
// on the single table memory port, the hand-off to the output register (S_FIN) and an idle
// state before the next accept. An unaligned map goes straight to the hand-off.
// A map adds, for each new table, a clear of the 512 entries of the frame and the write
// of the upper entry, all on the same memory port.
// After reset a clearing pass over the whole table memory runs with s_tready low.
// One request is in work at a time; a finished result may wait in the output register.
`default_nettype none

module four_level_page_table_walker #(
	parameter int unsigned TABLE_FRAMES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [47:0] virt_addr, [99:48] phys_addr, [111:100] map_flags,
	// [112] map_no_execute, [119:113] zero
	input  wire logic [119:0] s_tdata,
	// [0] req_type
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [51:0] translated_address, [63:52] result_flags, [64] result_no_execute,
	// [71:65] zero
	output logic [71:0]       m_tdata,
	// [2:0] status
	output logic [2:0]        m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [51:0]  cfg_data
);

	localparam int unsigned FW    = $clog2(TABLE_FRAMES);
	localparam int unsigned NW    = $clog2(TABLE_FRAMES + 1);
	localparam int unsigned DEPTH = TABLE_FRAMES * 512;
	localparam int unsigned IW    = fpw_pkg::IDX_W;
	localparam int unsigned AW    = FW + IW;
	localparam int unsigned PW    = fpw_pkg::PAGE_W;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]    state_q;
	logic [1:0]    lvl_q;
	logic [FW-1:0] frame_q;
	logic [NW-1:0] nff_q;
	logic [51:0]   pool_base_q;
	logic [AW-1:0] clr_q;
	logic          m_valid_q;

	// Request and result payload
	logic                rtype_q;
	logic [47:0]         va_q;
	logic [51:0]         pa_q;
	logic [11:0]         flags_q;
	logic                nx_q;
	logic [AW-1:0]       wr_addr_q;
	logic [63:0]         wr_data_q;
	fpw_pkg::status_t    res_status_q;
	logic [51:0]         res_addr_q;
	logic [11:0]         res_flags_q;
	logic                res_nx_q;
	fpw_pkg::status_t    m_status_q;
	logic [51:0]         m_addr_q;
	logic [11:0]         m_flags_q;
	logic                m_nx_q;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [63:0]   mem_wdata;
	logic [63:0]   mem_rdata;

	fpw_ram #(
		.WIDTH(fpw_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.addr (mem_addr),
		.we   (mem_we),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Decode of the entry just read
	logic          present;
	logic          huge;
	logic [51:0]   ent_addr;
	logic [51:0]   diff;
	logic          known;
	logic [FW-1:0] next_frame;
	logic [52:0]   alloc_sum;
	logic          alloc_ok;
	logic [63:0]   upper_entry;
	logic [63:0]   leaf_entry;
	logic [51:0]   xlat_addr;
	logic [AW-1:0] slot;
	logic          last_lvl;

	logic             in_accept;
	logic             in_unaligned;
	logic             ev_done;
	logic             ev_desc;
	logic             ev_alloc;
	logic             ev_leaf_wr;
	fpw_pkg::status_t ev_status;
	logic             fin_load;

	assign present    = mem_rdata[fpw_pkg::BIT_PRESENT];
	assign huge       = mem_rdata[fpw_pkg::BIT_HUGE];
	assign ent_addr   = {mem_rdata[51:12], 12'b0};
	assign diff       = ent_addr - pool_base_q;
	// Page alignment of the difference reduces to alignment of the pool base.
	assign known      = (ent_addr >= pool_base_q) && (pool_base_q[PW-1:0] == '0)
		&& (diff[51:12] < 40'(TABLE_FRAMES));
	assign next_frame = diff[FW+PW-1:PW];
	assign alloc_sum  = {1'b0, pool_base_q} + (53'(nff_q) << PW);
	assign alloc_ok   = (nff_q < NW'(TABLE_FRAMES)) && (pool_base_q[PW-1:0] == '0)
		&& !alloc_sum[52];
	assign upper_entry = {12'b0, alloc_sum[51:12], 9'b0, flags_q[fpw_pkg::BIT_USER],
		2'b11};
	assign leaf_entry = {nx_q, 11'b0, pa_q[51:12], flags_q};
	assign xlat_addr  = ent_addr + 52'(va_q[PW-1:0]);
	assign slot       = {frame_q, fpw_pkg::level_index(va_q, lvl_q)};
	assign last_lvl   = (lvl_q == 2'd3);

	assign in_accept    = s_tvalid && s_tready;
	assign in_unaligned = (s_tuser[0] == fpw_pkg::REQ_MAP)
		&& ((s_tdata[11:0] != '0) || (s_tdata[59:48] != '0));
	assign fin_load     = (state_q == S_FIN) && (!m_valid_q || m_tready);

	always_comb begin
		ev_done    = 1'b0;
		ev_desc    = 1'b0;
		ev_alloc   = 1'b0;
		ev_leaf_wr = 1'b0;
		ev_status  = fpw_pkg::ST_NOXLATE;
		if (!last_lvl) begin
			if (rtype_q == fpw_pkg::REQ_TRANSLATE) begin
				if (!present || huge || !known) begin
					ev_done = 1'b1;
				end else begin
					ev_desc = 1'b1;
				end
			end else if (present) begin
				if (huge || !known) begin
					ev_done   = 1'b1;
					ev_status = fpw_pkg::ST_ALLOC;
				end else begin
					ev_desc = 1'b1;
				end
			end else if (alloc_ok) begin
				ev_alloc = 1'b1;
			end else begin
				ev_done   = 1'b1;
				ev_status = fpw_pkg::ST_ALLOC;
			end
		end else begin
			ev_done = 1'b1;
			if (rtype_q == fpw_pkg::REQ_TRANSLATE) begin
				ev_status = present ? fpw_pkg::ST_XLATED : fpw_pkg::ST_NOXLATE;
			end else if (present) begin
				ev_status = fpw_pkg::ST_ALREADY;
			end else begin
				ev_status  = fpw_pkg::ST_MAPPED;
				ev_leaf_wr = 1'b1;
			end
		end
	end

	always_comb begin
		mem_addr  = slot;
		mem_we    = 1'b0;
		mem_wdata = '0;
		case (state_q)
			S_INIT, S_CLR: begin
				mem_addr = clr_q;
				mem_we   = 1'b1;
			end
			S_EV: begin
				mem_we    = ev_leaf_wr;
				mem_wdata = leaf_entry;
			end
			S_WR: begin
				mem_addr  = wr_addr_q;
				mem_we    = 1'b1;
				mem_wdata = wr_data_q;
			end
			default: begin
				mem_addr = slot;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			lvl_q       <= '0;
			frame_q     <= '0;
			nff_q       <= NW'(1);
			pool_base_q <= '0;
			clr_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_base_q <= cfg_data;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						lvl_q   <= '0;
						frame_q <= '0;
						state_q <= in_unaligned ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (ev_done) begin
						state_q <= S_FIN;
					end else if (ev_desc) begin
						frame_q <= next_frame;
						lvl_q   <= lvl_q + 2'd1;
						state_q <= S_RD;
					end else begin
						frame_q <= nff_q[FW-1:0];
						nff_q   <= nff_q + NW'(1);
						clr_q   <= {nff_q[FW-1:0], IW'(0)};
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q[IW-1:0]) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					lvl_q   <= lvl_q + 2'd1;
					state_q <= S_RD;
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rtype_q      <= s_tuser[0];
			va_q         <= s_tdata[47:0];
			pa_q         <= s_tdata[99:48];
			flags_q      <= s_tdata[111:100];
			nx_q         <= s_tdata[112];
			res_status_q <= fpw_pkg::ST_ALIGN;
			res_addr_q   <= '0;
			res_flags_q  <= '0;
			res_nx_q     <= 1'b0;
		end
		if (state_q == S_EV) begin
			wr_addr_q    <= slot;
			wr_data_q    <= upper_entry;
			res_status_q <= ev_status;
			if (ev_status == fpw_pkg::ST_XLATED) begin
				res_addr_q  <= xlat_addr;
				res_flags_q <= mem_rdata[11:0];
				res_nx_q    <= mem_rdata[fpw_pkg::BIT_NX];
			end else begin
				res_addr_q  <= '0;
				res_flags_q <= '0;
				res_nx_q    <= 1'b0;
			end
		end
		if (fin_load) begin
			m_status_q <= res_status_q;
			m_addr_q   <= res_addr_q;
			m_flags_q  <= res_flags_q;
			m_nx_q     <= res_nx_q;
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = m_status_q;
	assign m_tdata   = {7'b0, m_nx_q, m_flags_q, m_addr_q};

	// The frame counter never runs past the pool.
	assert property (@(posedge clk) disable iff (!arst_n)
		nff_q <= NW'(TABLE_FRAMES))
		else $error("frame allocator ran past the pool");

	// A frame is taken only as its clearing sweep starts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(nff_q != $past(nff_q)) |-> (state_q == S_CLR) && (clr_q[IW-1:0] == '0))
		else $error("frame taken without a clearing sweep");

	// Only a translated result carries address and flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != fpw_pkg::ST_XLATED)) |-> (m_tdata == '0))
		else $error("nonzero payload on a result that is not a translation");

	// A finished walk waits while the output register is still occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && m_valid_q && !m_tready) |=> (state_q == S_FIN))
		else $error("result overwrote a pending output");

endmodule

`default_nettype wire
